FILE: rtl/iat_pkg.sv
// Shared types, codes and helper functions for the interface address table.
package iat_pkg;

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 3;
   localparam int IDX_W   = 2;
   localparam int CNT_W   = 3;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_SET_MAIN = 3'd0,
      OP_ADD_SUB  = 3'd1,
      OP_DELETE   = 3'd2,
      OP_LOOKUP   = 3'd3,
      OP_BEST     = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EXISTS    = 3'd1,
      STAT_INVALID   = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEN_A     = 2'd0,
      CSR_LEN_B     = 2'd1,
      CSR_LEN_C     = 2'd2,
      CSR_LEN_OTHER = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_SHIFT,
      S_OUT
   } ctl_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  plen;
   } entry_type;

   // prefix length to netmask; lengths of 32 and above give a full mask
   function automatic logic [ADDR_W-1:0] len_to_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      begin
         if (len == '0)
            m = '0;
         else if (len >= LEN_W'(ADDR_W))
            m = '1;
         else
            m = ~({ADDR_W{1'b1}} >> len);
         return m;
      end
   endfunction

   // zero network, multicast, or global broadcast
   function automatic logic addr_invalid(input logic [ADDR_W-1:0] a);
      return (a[31:24] == 8'h00) || (a[31:28] == 4'hE) || (a == '1);
   endfunction

endpackage

FILE: rtl/iat_mem.sv
// Entry store: one write port, one read port with registered read data.
module iat_mem #(
   parameter int DEPTH = 4
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  iat_pkg::entry_type                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output iat_pkg::entry_type                          rd_data
);
   import iat_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/interface_address_table.sv
// Top level: IPv4 interface address table with exact lookup and subnet match.
// Sequence: accept in idle, scan the held entries through the single read port, then
//   execute, shift later entries down after a delete, and pass the result out.
// One op at a time: a new request is taken only in idle, after the scan, any delete
//   shift and the hand-off to the output register, which waits out an output stall.
// Reset: synchronous, active high; clears the entry count and loads the default
//   class lengths 8/16/24/32. Entry memory contents are not cleared.
module interface_address_table #(
   parameter int MAX_ENTRIES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [iat_pkg::OP_W-1:0]      req_op,
   input  logic [iat_pkg::ADDR_W-1:0]    req_addr,
   input  logic [iat_pkg::LEN_W-1:0]     req_prefix_len,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [iat_pkg::STAT_W-1:0]    rsp_status,
   output logic [iat_pkg::IDX_W-1:0]     rsp_entry_index,
   output logic                          rsp_local_bcast,
   output logic [iat_pkg::CNT_W-1:0]     rsp_entry_count,
   // configuration
   input  logic                          csr_we,
   input  logic [iat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [iat_pkg::LEN_W-1:0]     csr_wdata
);
   import iat_pkg::*;

   // IW indexes the table, CW holds 0..MAX_ENTRIES
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   // ---------------------------------------------------------------
   // Default class prefix lengths
   // ---------------------------------------------------------------
   logic [LEN_W-1:0] len_a_ff, len_b_ff, len_c_ff, len_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= LEN_W'(8);
         len_b_ff <= LEN_W'(16);
         len_c_ff <= LEN_W'(24);
         len_o_ff <= LEN_W'(32);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEN_A:     len_a_ff <= csr_wdata;
            CSR_LEN_B:     len_b_ff <= csr_wdata;
            CSR_LEN_C:     len_c_ff <= csr_wdata;
            CSR_LEN_OTHER: len_o_ff <= csr_wdata;
            default:       len_o_ff <= len_o_ff;
         endcase
      end
   end

   // resolved prefix for a set op: explicit length, else class default
   logic [LEN_W-1:0] req_len_res;
   always_comb begin
      if (req_prefix_len != '0)
         req_len_res = req_prefix_len;
      else if (!req_addr[31])
         req_len_res = len_a_ff;
      else if (req_addr[31:30] == 2'b10)
         req_len_res = len_b_ff;
      else if (req_addr[31:29] == 3'b110)
         req_len_res = len_c_ff;
      else
         req_len_res = len_o_ff;
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   ctl_state_type     state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_ptr_ff, rd_ptr_in;    // next entry to read
   logic              pend_ff, pend_in;        // read data arrives this cycle
   logic [IW-1:0]     pend_idx_ff, pend_idx_in;
   logic              exact_hit_ff, exact_hit_in;
   logic [IW-1:0]     exact_idx_ff, exact_idx_in;
   logic              best_hit_ff, best_hit_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [IW-1:0]     res_idx_ff, res_idx_in;
   logic              res_bc_ff, res_bc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_bc_ff, rsp_bc_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // memory port
   logic              mem_we;
   logic [IW-1:0]     mem_waddr;
   entry_type         mem_wdata;
   logic [IW-1:0]     mem_raddr;
   entry_type         mem_rdata;

   iat_mem #(
      .DEPTH (MAX_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      plen_ff       <= plen_in;
      rd_ptr_ff     <= rd_ptr_in;
      pend_idx_ff   <= pend_idx_in;
      exact_hit_ff  <= exact_hit_in;
      exact_idx_ff  <= exact_idx_in;
      best_hit_ff   <= best_hit_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_bc_ff     <= res_bc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_bc_ff     <= rsp_bc_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] ent_mask;
   logic [ADDR_W-1:0] best_mask;
   logic [CW-1:0]     del_next;     // entry just above the deleted one
   logic [IW+1:0]     idx_ext;
   logic [CW+2:0]     cnt_ext;

   assign ent_mask  = len_to_mask(mem_rdata.plen);
   assign best_mask = len_to_mask(best_len_ff);
   assign del_next  = CW'(exact_idx_ff) + CW'(1);
   assign idx_ext   = {2'b00, res_idx_ff};
   assign cnt_ext   = {3'b000, count_ff};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      plen_in       = plen_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      exact_hit_in  = exact_hit_ff;
      exact_idx_in  = exact_idx_ff;
      best_hit_in   = best_hit_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_bc_in     = res_bc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_bc_in     = rsp_bc_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = pend_idx_ff;
      mem_wdata     = mem_rdata;
      mem_raddr     = rd_ptr_ff[IW-1:0];
      req_stall     = 1'b1;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in        = req_op;
               addr_in      = req_addr;
               plen_in      = req_len_res;
               rd_ptr_in    = '0;
               exact_hit_in = 1'b0;
               best_hit_in  = 1'b0;
               state_in     = S_SCAN;
            end
         end

         // walk the valid entries: one read issued, one compared per cycle
         S_SCAN: begin
            if (rd_ptr_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_ptr_ff[IW-1:0];
               rd_ptr_in   = rd_ptr_ff + CW'(1);
            end
            if (pend_ff) begin
               if (!exact_hit_ff && mem_rdata.addr == addr_ff) begin
                  exact_hit_in = 1'b1;
                  exact_idx_in = pend_idx_ff;
               end
               if (!best_hit_ff && mem_rdata.addr != '0 &&
                   (mem_rdata.addr & ent_mask) == (addr_ff & ent_mask)) begin
                  best_hit_in = 1'b1;
                  best_idx_in = pend_idx_ff;
                  best_len_in = mem_rdata.plen;
               end
            end
            if (!pend_ff && rd_ptr_ff >= count_ff)
               state_in = S_EXEC;
         end

         S_EXEC: begin
            res_status_in = STAT_OK;
            res_idx_in    = '0;
            res_bc_in     = 1'b0;
            state_in      = S_OUT;
            mem_wdata     = '{addr: addr_ff, plen: plen_ff};
            case (op_type'(op_ff))
               OP_SET_MAIN: begin
                  if (exact_hit_ff)
                     res_status_in = STAT_EXISTS;
                  else if (addr_invalid(addr_ff))
                     res_status_in = STAT_INVALID;
                  else begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     if (count_ff == '0)
                        count_in = CW'(1);
                  end
               end
               OP_ADD_SUB: begin
                  if (count_ff >= MAX_CNT)
                     res_status_in = STAT_FULL;
                  else if (addr_invalid(addr_ff))
                     res_status_in = STAT_INVALID;
                  else if (exact_hit_ff)
                     res_status_in = STAT_EXISTS;
                  else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[IW-1:0];
                     count_in  = count_ff + CW'(1);
                  end
               end
               OP_DELETE: begin
                  if (!exact_hit_ff)
                     res_status_in = STAT_NOT_FOUND;
                  else begin
                     count_in = count_ff - CW'(1);
                     if (del_next < count_ff) begin
                        rd_ptr_in = del_next;
                        state_in  = S_SHIFT;
                     end
                  end
               end
               OP_LOOKUP: begin
                  if (!exact_hit_ff)
                     res_status_in = STAT_NOT_FOUND;
                  else
                     res_idx_in = exact_idx_ff;
               end
               OP_BEST: begin
                  if (!best_hit_ff)
                     res_status_in = STAT_NOT_FOUND;
                  else begin
                     res_idx_in = best_idx_ff;
                     res_bc_in  = ((addr_ff | best_mask) == '1);
                  end
               end
               default: res_status_in = STAT_INVALID;
            endcase
         end

         // move later entries down: read i+1, write i the next cycle.
         // count_ff already holds the reduced count, so old count = count_ff + 1.
         S_SHIFT: begin
            if (rd_ptr_ff <= count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = IW'(rd_ptr_ff - CW'(1));
               rd_ptr_in   = rd_ptr_ff + CW'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_idx_ff;
               mem_wdata = mem_rdata;
            end
            if (!pend_ff && rd_ptr_ff > count_ff)
               state_in = S_OUT;
         end

         // hand the result to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = idx_ext[IDX_W-1:0];
               rsp_bc_in     = res_bc_ff;
               rsp_count_in  = cnt_ext[CNT_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_local_bcast = rsp_bc_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
